// ===== hw/rtl/bde_pkg.sv =====
// Shared types, sizes and helpers for the binary disk erode/dilate block.
// Used by every module of the block; depends on nothing.
package bde_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_RADIUS = 7;
   localparam int WIN        = 2 * MAX_RADIUS + 1;
   localparam int HIST_W     = WIN - 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W      = 11;
   localparam int RAD_W      = 3;
   localparam int LAG_W      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2,
      REG_MODE   = 2'd3
   } reg_index_type;

   typedef logic [WIN-1:0] col_vec_type;

   typedef struct packed {
      logic [RAD_W-1:0] radius;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             mode;
   } cfg_type;

   typedef struct packed {
      col_vec_type      vec;
      logic             emit;
      logic             last;
      logic [DIM_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
   } slot_type;

   function automatic logic in_disk(input logic [RAD_W-1:0] r, input int d, input int k);
      int dr;
      int dk;
      int rr;
      rr = int'(r);
      dr = d - rr;
      dk = k - rr;
      return (dr * dr + dk * dk) <= (rr * rr);
   endfunction

endpackage

// ===== hw/rtl/bde_front.sv =====
// Front end: takes words, tracks frame position, keeps the column line store.
// Pushes one column slot per position into the queue; uses bde_pkg.
module bde_front (
   input  logic                       clock,
   input  logic                       reset,
   input  bde_pkg::cfg_type           cfg,
   input  logic                       restart,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic                       req_pixel_in,
   input  logic [bde_pkg::QPTR_W:0]   q_space,
   output logic                       q_push,
   output bde_pkg::slot_type          q_slot
);

   logic [bde_pkg::COL_W-1:0]  in_col_ff, in_col_in;
   logic [bde_pkg::DIM_W-1:0]  in_row_ff, in_row_in;
   logic [bde_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [bde_pkg::DIM_W-1:0]  out_row_ff, out_row_in;
   logic [bde_pkg::LAG_W-1:0]  lag_ff, lag_in;
   logic                       owe_ff, owe_in;

   logic                       s1_valid_ff;
   logic                       s1_pix_ff;
   logic [bde_pkg::COL_W-1:0]  s1_col_ff;
   logic                       s1_fwd_ff;
   logic                       s1_emit_ff;
   logic                       s1_last_ff;
   logic [bde_pkg::DIM_W-1:0]  s1_orow_ff;
   logic [bde_pkg::COL_W-1:0]  s1_ocol_ff;

   logic [bde_pkg::HIST_W-1:0] line_store [bde_pkg::MAX_WIDTH];
   logic [bde_pkg::HIST_W-1:0] rdata_ff;
   logic [bde_pkg::HIST_W-1:0] wvec_ff;

   logic [bde_pkg::LAG_W-1:0]  thresh;
   logic                       drain;
   logic                       started;
   logic                       catch_up;
   logic                       step_ok;
   logic                       accept;
   logic                       step;
   logic                       pix;
   logic                       last;
   logic [bde_pkg::HIST_W-1:0] s1_hist;
   logic [bde_pkg::WIN-1:0]    s1_vec;

   always_comb begin
      thresh   = bde_pkg::LAG_W'(cfg.radius) * bde_pkg::LAG_W'(cfg.width)
               + bde_pkg::LAG_W'(cfg.radius);
      drain    = in_row_ff >= cfg.height;
      started  = lag_ff == thresh;
      catch_up = drain && (!started || owe_ff);
      step_ok  = q_space > {{bde_pkg::QPTR_W{1'b0}}, s1_valid_ff};
      req_ready = step_ok && !catch_up;
      accept   = req_valid && req_ready;
      step     = (accept && (req_cmd == drain)) || (catch_up && step_ok);
      pix      = !drain && req_pixel_in;
      last     = started && (out_row_ff == cfg.height - bde_pkg::DIM_W'(1))
               && ({1'b0, out_col_ff} == cfg.width - bde_pkg::DIM_W'(1));
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_in     = lag_ff;
      owe_in     = owe_ff;
      if (restart || (step && last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lag_in     = '0;
         owe_in     = 1'b0;
      end else if (step) begin
         if (({1'b0, in_col_ff} + bde_pkg::DIM_W'(1)) >= cfg.width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + bde_pkg::DIM_W'(1);
         end else begin
            in_col_in = in_col_ff + bde_pkg::COL_W'(1);
         end
         if (!started) begin
            lag_in = lag_ff + bde_pkg::LAG_W'(1);
            if (!drain && (in_row_in >= cfg.height)) begin
               owe_in = 1'b1;
            end
         end else begin
            owe_in = 1'b0;
            if (({1'b0, out_col_ff} + bde_pkg::DIM_W'(1)) >= cfg.width) begin
               out_col_in = '0;
               out_row_in = out_row_ff + bde_pkg::DIM_W'(1);
            end else begin
               out_col_in = out_col_ff + bde_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         lag_ff      <= '0;
         owe_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         lag_ff      <= lag_in;
         owe_ff      <= owe_in;
         s1_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_pix_ff  <= pix;
         s1_col_ff  <= in_col_ff;
         s1_fwd_ff  <= s1_valid_ff && (s1_col_ff == in_col_ff);
         s1_emit_ff <= started;
         s1_last_ff <= last;
         s1_orow_ff <= out_row_ff;
         s1_ocol_ff <= out_col_ff;
      end
   end

   always_comb begin
      s1_hist = s1_fwd_ff ? wvec_ff : rdata_ff;
      s1_vec  = {s1_hist, s1_pix_ff};
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_store[s1_col_ff] <= s1_vec[bde_pkg::HIST_W-1:0];
         wvec_ff               <= s1_vec[bde_pkg::HIST_W-1:0];
      end
      rdata_ff <= line_store[in_col_ff];
   end

   always_comb begin
      q_push         = s1_valid_ff;
      q_slot.vec     = s1_vec;
      q_slot.emit    = s1_emit_ff;
      q_slot.last    = s1_last_ff;
      q_slot.out_row = s1_orow_ff;
      q_slot.out_col = s1_ocol_ff;
   end

endmodule

// ===== hw/rtl/bde_queue.sv =====
// Short slot queue between front and back ends.
// Uses bde_pkg for the slot type and depth.
module bde_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bde_pkg::slot_type        push_slot,
   input  logic                     pop,
   output logic                     head_valid,
   output bde_pkg::slot_type        head_slot,
   output logic [bde_pkg::QPTR_W:0] space
);

   bde_pkg::slot_type           slots_ff [bde_pkg::QDEPTH];
   logic [bde_pkg::QPTR_W-1:0]  wr_ff, wr_in;
   logic [bde_pkg::QPTR_W-1:0]  rd_ff, rd_in;
   logic [bde_pkg::QPTR_W:0]    count_ff, count_in;

   always_comb begin
      wr_in    = push ? wr_ff + bde_pkg::QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + bde_pkg::QPTR_W'(1) : rd_ff;
      count_in = count_ff + {{bde_pkg::QPTR_W{1'b0}}, push}
               - {{bde_pkg::QPTR_W{1'b0}}, pop};
      head_valid = count_ff != '0;
      head_slot  = slots_ff[rd_ff];
      space      = (bde_pkg::QPTR_W+1)'(bde_pkg::QDEPTH) - count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_slot;
      end
   end

endmodule

// ===== hw/rtl/bde_back.sv =====
// Back end: shifts column slots into the disk window and forms result words.
// Holds the output register; uses bde_pkg.
module bde_back (
   input  logic              clock,
   input  logic              reset,
   input  bde_pkg::cfg_type  cfg,
   input  logic              head_valid,
   input  bde_pkg::slot_type head_slot,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_pixel_out,
   output logic              rsp_frame_last
);

   bde_pkg::col_vec_type window_ff [bde_pkg::WIN];
   bde_pkg::col_vec_type window_in [bde_pkg::WIN];
   logic                 valid_ff, valid_in;
   logic                 pixel_ff;
   logic                 last_ff;
   logic [bde_pkg::WIN-1:0] row_ok;
   logic [bde_pkg::WIN-1:0] col_ok;
   logic                 and_acc;
   logic                 or_acc;
   logic                 bit_val;
   logic                 result;
   int                   pos;

   always_comb begin
      pop = head_valid && (!head_slot.emit || !valid_ff || rsp_ready);
      window_in[0] = head_slot.vec;
      for (int k = 1; k < bde_pkg::WIN; k++) begin
         window_in[k] = window_ff[k-1];
      end
      for (int d = 0; d < bde_pkg::WIN; d++) begin
         pos = int'(head_slot.out_row) + int'(cfg.radius) - d;
         row_ok[d] = (pos >= 0) && (pos < int'(cfg.height));
      end
      for (int k = 0; k < bde_pkg::WIN; k++) begin
         pos = int'(head_slot.out_col) + int'(cfg.radius) - k;
         col_ok[k] = (pos >= 0) && (pos < int'(cfg.width));
      end
      and_acc = 1'b1;
      or_acc  = 1'b0;
      bit_val = 1'b0;
      for (int d = 0; d < bde_pkg::WIN; d++) begin
         for (int k = 0; k < bde_pkg::WIN; k++) begin
            if (bde_pkg::in_disk(cfg.radius, d, k)) begin
               bit_val = window_in[k][d] && row_ok[d] && col_ok[k];
               and_acc = and_acc && bit_val;
               or_acc  = or_acc || bit_val;
            end
         end
      end
      result = cfg.mode ? or_acc : and_acc;
      if (pop && head_slot.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         window_ff <= window_in;
      end
      if (pop && head_slot.emit) begin
         pixel_ff <= result;
         last_ff  <= head_slot.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pixel_out  = pixel_ff;
   assign rsp_frame_last = last_ff;

endmodule

// ===== hw/rtl/binary_disk_erode_dilate.sv =====
// Top level of the binary disk erode/dilate block: register port and wiring.
// Instantiates bde_front, bde_queue and bde_back; uses bde_pkg.
//
// Input words (req_) carry one pixel in raster order (req_cmd 0) or a flush
// (req_cmd 1). Result words (rsp_) carry the eroded (mode 0) or dilated
// (mode 1) pixel, in raster order, with rsp_frame_last on the frame's last.
// The structuring element is a filled disk of the programmed radius.
// A result becomes due once radius rows plus radius pixels beyond it have
// arrived; it passes the front-end stage register, the slot queue and the
// output register to reach rsp_, and waits longer if the queue holds words.
// After the frame's last pixel, each flush word drains one result.
// Throughput: one word per cycle while req_ready stays high, set by the line
// store's read and write of one column per cycle in the front end.
// When a frame holds no more than radius*width+radius pixels, req_ready drops
// after its last pixel until its first result has formed.
// A stalled rsp_ side fills the four-slot queue, then req_ready drops.
// Reset clears counters, queue and output; the line store needs no clear.
// Any register write restarts the frame position.
module binary_disk_erode_dilate (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic                       req_pixel_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pixel_out,
   output logic                       rsp_frame_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bde_pkg::ADDR_W-1:0] paddr,
   input  logic [bde_pkg::DATA_W-1:0] pwdata,
   output logic [bde_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [bde_pkg::RAD_W-1:0] radius_ff, radius_in;
   logic [bde_pkg::DIM_W-1:0] width_ff, width_in;
   logic [bde_pkg::DIM_W-1:0] height_ff, height_in;
   logic                      mode_ff, mode_in;
   logic                      wr_en;
   bde_pkg::reg_index_type    reg_idx;
   bde_pkg::cfg_type          cfg;

   logic                      q_push;
   bde_pkg::slot_type         q_slot;
   logic                      q_pop;
   logic                      q_valid;
   bde_pkg::slot_type         q_head;
   logic [bde_pkg::QPTR_W:0]  q_space;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = bde_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      radius_in = radius_ff;
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (wr_en) begin
         unique case (reg_idx)
            bde_pkg::REG_RADIUS: radius_in = pwdata[bde_pkg::RAD_W-1:0];
            bde_pkg::REG_WIDTH:  width_in  = pwdata[bde_pkg::DIM_W-1:0];
            bde_pkg::REG_HEIGHT: height_in = pwdata[bde_pkg::DIM_W-1:0];
            bde_pkg::REG_MODE:   mode_in   = pwdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= bde_pkg::RAD_W'(1);
         width_ff  <= bde_pkg::DIM_W'(640);
         height_ff <= bde_pkg::DIM_W'(480);
         mode_ff   <= 1'b0;
      end else begin
         radius_ff <= radius_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         bde_pkg::REG_RADIUS: prdata = bde_pkg::DATA_W'(radius_ff);
         bde_pkg::REG_WIDTH:  prdata = bde_pkg::DATA_W'(width_ff);
         bde_pkg::REG_HEIGHT: prdata = bde_pkg::DATA_W'(height_ff);
         bde_pkg::REG_MODE:   prdata = bde_pkg::DATA_W'(mode_ff);
      endcase
   end

   always_comb begin
      cfg.radius = (32'(radius_ff) > 32'(bde_pkg::MAX_RADIUS))
                 ? bde_pkg::RAD_W'(bde_pkg::MAX_RADIUS) : radius_ff;
      if (width_ff == '0) begin
         cfg.width = bde_pkg::DIM_W'(1);
      end else if (32'(width_ff) > 32'(bde_pkg::MAX_WIDTH)) begin
         cfg.width = bde_pkg::DIM_W'(bde_pkg::MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      cfg.height = (height_ff == '0) ? bde_pkg::DIM_W'(1) : height_ff;
      cfg.mode   = mode_ff;
   end

   bde_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .restart      (wr_en),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_pixel_in (req_pixel_in),
      .q_space      (q_space),
      .q_push       (q_push),
      .q_slot       (q_slot)
   );

   bde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_slot  (q_slot),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_slot  (q_head),
      .space      (q_space)
   );

   bde_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .head_valid     (q_valid),
      .head_slot      (q_head),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_space != '0 || q_pop))
      else $error("slot queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("slot queue underflow");

   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (q_space != '0))
      else $error("input taken without queue room");

endmodule
